/* design/acs_pkg.sv */
// shared types, constants and helpers for the aligned channel split block
// no dependencies; imported by acs_geom, aligned_channel_split and the testbench

package acs_pkg;

   // default sizing handed to the top-level parameters
   localparam int ACS_MAX_PARTS = 4;
   localparam int ACS_ALIGN     = 16;

   // field limits fixed by the register widths
   localparam logic [11:0] MAX_DIM = 12'd2048;
   localparam logic [11:0] MAX_CH  = 12'd1024;

   // product of channel sum (13 bits) and width (12 bits) never exceeds 2^23
   localparam int PROD_W   = 24;
   // one part's padded row size: at most 1024 * 2048 plus alignment padding
   localparam int STRIDE_W = 22;

   // configuration register indexes
   localparam logic [2:0] REG_PART_COUNT = 3'd0;
   localparam logic [2:0] REG_HEIGHT     = 3'd1;
   localparam logic [2:0] REG_WIDTH      = 3'd2;
   localparam logic [2:0] REG_PART0_CH   = 3'd3;
   localparam logic [2:0] REG_PART1_CH   = 3'd4;
   localparam logic [2:0] REG_PART2_CH   = 3'd5;
   localparam logic [2:0] REG_PART3_CH   = 3'd6;

   typedef struct packed {
      logic [2:0]       part_count;
      logic [11:0]      image_height;
      logic [11:0]      image_width;
      logic [3:0][10:0] part_channels;
   } acs_cfg_type;

   // zero acts as one, anything above the limit acts as the limit
   function automatic logic [11:0] clamp_reg(input logic [11:0] value,
                                             input logic [11:0] limit);
      logic [11:0] result;
      if (value == 12'd0) begin
         result = 12'd1;
      end else if (value > limit) begin
         result = limit;
      end else begin
         result = value;
      end
      return result;
   endfunction

endpackage

/* design/acs_channels.sv */
// valid/ready channel interfaces for the aligned channel split block
// no dependencies

interface acs_req_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] pixel_byte;

   modport source (output valid, output pixel_byte, input ready);
   modport sink   (input valid, input pixel_byte, output ready);
endinterface

interface acs_rsp_if;
   logic              valid;
   logic              ready;
   logic [1:0]        part_index;
   logic [31:0]       dest_offset;
   logic signed [7:0] out_byte;
   logic              image_done;

   modport source (output valid, output part_index, output dest_offset,
                   output out_byte, output image_done, input ready);
   modport sink   (input valid, input part_index, input dest_offset,
                   input out_byte, input image_done, output ready);
endinterface

/* design/acs_geom.sv */
// row geometry unit: padded row size of each part and source row padding
// depends on acs_pkg; one shared multiplier and a reciprocal-multiply remainder

module acs_geom import acs_pkg::*; #(
   parameter int MAX_PARTS = ACS_MAX_PARTS,
   parameter int ALIGN     = ACS_ALIGN
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   input  acs_cfg_type                              cfg,
   output logic                                     busy,
   output logic [((ALIGN > 1) ? $clog2(ALIGN) : 1)-1:0] row_pad,
   output logic [STRIDE_W-1:0]                      strides [MAX_PARTS]
);

   localparam int PAD_W  = (ALIGN > 1) ? $clog2(ALIGN) : 1;
   localparam int R_W    = $clog2(ALIGN) + 1;
   localparam int JOB_W  = $clog2(MAX_PARTS + 1);
   localparam int PART_W = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;

   // scaled reciprocal of ALIGN, exact quotient for every product below 2^PROD_W
   localparam int RCP_SH = PROD_W + $clog2(ALIGN);
   localparam int RCP_W  = PROD_W + 1;
   localparam int QP_W   = PROD_W + RCP_W;
   localparam logic [RCP_W-1:0] RECIP =
      RCP_W'(((64'd1 << RCP_SH) + 64'(ALIGN) - 64'd1) / 64'(ALIGN));

   localparam logic [PROD_W-1:0]  ALIGN_P  = PROD_W'(ALIGN);
   localparam logic [R_W-1:0]     ALIGN_R  = R_W'(ALIGN);
   localparam logic [JOB_W-1:0]   LAST_JOB = JOB_W'(MAX_PARTS);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_REM   = 3'd3;
   localparam logic [2:0] ST_STORE = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [JOB_W-1:0]    job_ff, job_in;
   logic [PROD_W-1:0]   prod_ff;
   logic [PROD_W-1:0]   quot_ff;
   logic [R_W-1:0]      rem_ff;
   logic [PAD_W-1:0]    row_pad_ff;
   logic [STRIDE_W-1:0] stride_ff [MAX_PARTS];

   logic [12:0]         total;
   logic [12:0]         mul_a;
   logic [24:0]         prod_full;
   logic [2:0]          job_ext;
   logic [QP_W-1:0]     recip_prod;
   logic [QP_W-1:0]     quot_full;
   logic [PROD_W-1:0]   rem_full;
   logic [R_W-1:0]      pad_full;
   logic [PAD_W-1:0]    pad_val;
   logic [STRIDE_W-1:0] stride_val;
   logic [PART_W-1:0]   job_part;

   // channel sum over the active parts
   always_comb begin
      total = 13'd0;
      for (int i = 0; i < 4; i++) begin
         if (3'(i) < cfg.part_count) begin
            total = total + 13'(cfg.part_channels[i]);
         end
      end
   end

   assign job_ext   = 3'(job_ff);
   assign job_part  = PART_W'(job_ff);
   assign mul_a     = (job_ff < LAST_JOB) ? 13'(cfg.part_channels[job_ext[1:0]]) : total;
   assign prod_full = {12'd0, mul_a} * {13'd0, cfg.image_width};

   // quotient by reciprocal multiply, remainder from the registered quotient in the following state
   assign recip_prod = {{RCP_W{1'b0}}, prod_ff} * {{PROD_W{1'b0}}, RECIP};
   assign quot_full  = recip_prod >> RCP_SH;
   assign rem_full   = prod_ff - (quot_ff * ALIGN_P);

   assign pad_full = (rem_ff == '0) ? '0 : (ALIGN_R - rem_ff);
   assign pad_val  = pad_full[PAD_W-1:0];
   assign stride_val = prod_ff[STRIDE_W-1:0] + STRIDE_W'(pad_val);

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_MUL: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            state_in = ST_REM;
         end
         ST_REM: begin
            state_in = ST_STORE;
         end
         ST_STORE: begin
            if (job_ff == LAST_JOB) begin
               state_in = ST_IDLE;
            end else begin
               job_in   = job_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // a configuration write restarts the whole sweep
      if (start) begin
         state_in = ST_MUL;
         job_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_MUL;
         job_ff   <= '0;
      end else begin
         state_ff <= state_in;
         job_ff   <= job_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL) begin
         prod_ff <= prod_full[PROD_W-1:0];
      end
      if (state_ff == ST_DIV) begin
         quot_ff <= quot_full[PROD_W-1:0];
      end
      if (state_ff == ST_REM) begin
         rem_ff <= rem_full[R_W-1:0];
      end
      if (state_ff == ST_STORE) begin
         if (job_ff == LAST_JOB) begin
            row_pad_ff <= pad_val;
         end else begin
            stride_ff[job_part] <= stride_val;
         end
      end
   end

   assign busy    = (state_ff != ST_IDLE);
   assign row_pad = row_pad_ff;
   assign strides = stride_ff;

endmodule

/* design/aligned_channel_split.sv */
// aligned channel split: a result is registered after its byte is accepted
// (one memory stage, one output register)
// throughput: one source byte per cycle unless stalled; padding bytes give no transfer
// after reset and after every csr write the input is held off while the geometry unit
// recomputes row sizes with one shared multiplier
// reset (synchronous) sets config registers to 1, clears counters, row bases and pointer valid bits

module aligned_channel_split import acs_pkg::*; #(
   parameter int MAX_PARTS = ACS_MAX_PARTS,
   parameter int ALIGN     = ACS_ALIGN
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [2:0]        csr_index,
   input  logic [11:0]       csr_wdata,
   acs_req_if.sink           req_chan,
   acs_rsp_if.source         rsp_chan
);

   localparam int PAD_W  = (ALIGN > 1) ? $clog2(ALIGN) : 1;
   localparam int PART_W = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;

   // configuration registers, stored already clamped
   acs_cfg_type cfg_ff, cfg_in;

   // position counters
   logic [10:0]      row_ff, row_in;
   logic [10:0]      col_ff, col_in;
   logic [PART_W-1:0] part_ff, part_in;
   logic [9:0]       chan_ff, chan_in;
   logic [PAD_W-1:0] pad_ff, pad_in;

   // geometry unit results
   logic                geom_busy;
   logic [PAD_W-1:0]    row_pad;
   logic [STRIDE_W-1:0] strides [MAX_PARTS];

   // memory stage
   logic              s1_valid_ff, s1_valid_in;
   logic [PART_W-1:0] s1_part_ff;
   logic signed [7:0] s1_byte_ff;
   logic              s1_row_end_ff;
   logic              s1_done_ff;
   logic              s1_fwd_ff;
   logic [31:0]       s1_fwd_data_ff;
   logic [31:0]       rd_data_ff;

   // write pointer store, with one valid bit per part; invalid reads as row base
   logic [31:0]          wp_mem [MAX_PARTS];
   logic [MAX_PARTS-1:0] wp_valid_ff, wp_valid_in;
   logic [31:0]          row_base_ff [MAX_PARTS];
   logic [31:0]          row_base_in [MAX_PARTS];

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        out_part_ff;
   logic [31:0]       out_offset_ff;
   logic signed [7:0] out_byte_ff;
   logic              out_done_ff;

   logic        req_fire;
   logic        emit;
   logic        out_free;
   logic        s1_go;
   logic [10:0] ch_lim;
   logic        chan_last, part_last, col_last, row_last, row_end, img_end;
   logic [31:0] wp_cur, wp_next;

   //------------------------------------------------------------------
   // configuration writes
   //------------------------------------------------------------------
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_PART_COUNT: cfg_in.part_count =
               3'(clamp_reg({9'd0, csr_wdata[2:0]}, 12'(MAX_PARTS)));
            REG_HEIGHT:   cfg_in.image_height = clamp_reg(csr_wdata, MAX_DIM);
            REG_WIDTH:    cfg_in.image_width  = clamp_reg(csr_wdata, MAX_DIM);
            REG_PART0_CH: cfg_in.part_channels[0] =
               11'(clamp_reg({1'b0, csr_wdata[10:0]}, MAX_CH));
            REG_PART1_CH: cfg_in.part_channels[1] =
               11'(clamp_reg({1'b0, csr_wdata[10:0]}, MAX_CH));
            REG_PART2_CH: cfg_in.part_channels[2] =
               11'(clamp_reg({1'b0, csr_wdata[10:0]}, MAX_CH));
            REG_PART3_CH: cfg_in.part_channels[3] =
               11'(clamp_reg({1'b0, csr_wdata[10:0]}, MAX_CH));
            default: begin
            end
         endcase
      end
   end

   // padded row sizes and source padding, recomputed after each write
   acs_geom #(
      .MAX_PARTS (MAX_PARTS),
      .ALIGN     (ALIGN)
   ) u_geom (
      .clock   (clock),
      .reset   (reset),
      .start   (csr_wr_en),
      .cfg     (cfg_ff),
      .busy    (geom_busy),
      .row_pad (row_pad),
      .strides (strides)
   );

   //------------------------------------------------------------------
   // handshake: the output register parts the two sides
   //------------------------------------------------------------------
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign s1_go          = s1_valid_ff && out_free;
   assign req_chan.ready = !geom_busy && (!s1_valid_ff || out_free);
   assign req_fire       = req_chan.valid && req_chan.ready;
   // padding bytes are swallowed here and never reach the memory stage
   assign emit           = req_fire && (pad_ff == '0);

   //------------------------------------------------------------------
   // position counters; each end test is "reached or passed"
   //------------------------------------------------------------------
   assign ch_lim    = cfg_ff.part_channels[2'(part_ff)];
   assign chan_last = (11'(chan_ff) + 11'd1) >= ch_lim;
   assign part_last = (3'(part_ff) + 3'd1) >= cfg_ff.part_count;
   assign col_last  = (12'(col_ff) + 12'd1) >= cfg_ff.image_width;
   assign row_last  = (12'(row_ff) + 12'd1) >= cfg_ff.image_height;
   assign row_end   = chan_last && part_last && col_last;
   assign img_end   = row_end && row_last;

   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      part_in = part_ff;
      chan_in = chan_ff;
      pad_in  = pad_ff;
      if (req_fire) begin
         if (pad_ff != '0) begin
            pad_in = pad_ff - 1'b1;
         end else if (!chan_last) begin
            chan_in = chan_ff + 10'd1;
         end else begin
            chan_in = '0;
            if (!part_last) begin
               part_in = part_ff + 1'b1;
            end else begin
               part_in = '0;
               if (!col_last) begin
                  col_in = col_ff + 11'd1;
               end else begin
                  col_in = '0;
                  // source row padding from the registers as they stand now
                  pad_in = row_pad;
                  row_in = row_last ? 11'd0 : (row_ff + 11'd1);
               end
            end
         end
      end
   end

   //------------------------------------------------------------------
   // memory stage: read-modify-write of the part's write pointer
   //------------------------------------------------------------------
   always_comb begin
      if (!wp_valid_ff[s1_part_ff]) begin
         wp_cur = row_base_ff[s1_part_ff];
      end else if (s1_fwd_ff) begin
         // previous transfer wrote this part at the edge this one was read
         wp_cur = s1_fwd_data_ff;
      end else begin
         wp_cur = rd_data_ff;
      end
   end
   assign wp_next = wp_cur + 32'd1;

   always_comb begin
      wp_valid_in = wp_valid_ff;
      row_base_in = row_base_ff;
      if (s1_go) begin
         if (s1_row_end_ff) begin
            // every pointer falls back to its (new) row base
            wp_valid_in = '0;
            for (int i = 0; i < MAX_PARTS; i++) begin
               row_base_in[i] = s1_done_ff ? 32'd0 : (row_base_ff[i] + 32'(strides[i]));
            end
         end else begin
            wp_valid_in[s1_part_ff] = 1'b1;
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (emit) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // pointer memory, registered read
   always_ff @(posedge clock) begin
      if (s1_go) begin
         wp_mem[s1_part_ff] <= wp_next;
      end
      if (emit) begin
         rd_data_ff <= wp_mem[part_ff];
      end
   end

   // stage and output payload
   always_ff @(posedge clock) begin
      if (emit) begin
         s1_part_ff     <= part_ff;
         s1_byte_ff     <= req_chan.pixel_byte;
         s1_row_end_ff  <= row_end;
         s1_done_ff     <= img_end;
         s1_fwd_ff      <= s1_go && (s1_part_ff == part_ff);
         s1_fwd_data_ff <= wp_next;
      end
      if (s1_go) begin
         out_part_ff   <= 2'(s1_part_ff);
         out_offset_ff <= wp_cur;
         out_byte_ff   <= s1_byte_ff;
         out_done_ff   <= s1_done_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.part_count   <= 3'd1;
         cfg_ff.image_height <= 12'd1;
         cfg_ff.image_width  <= 12'd1;
         for (int i = 0; i < 4; i++) begin
            cfg_ff.part_channels[i] <= 11'd1;
         end
         row_ff       <= '0;
         col_ff       <= '0;
         part_ff      <= '0;
         chan_ff      <= '0;
         pad_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         wp_valid_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_PARTS; i++) begin
            row_base_ff[i] <= '0;
         end
      end else begin
         cfg_ff       <= cfg_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         part_ff      <= part_in;
         chan_ff      <= chan_in;
         pad_ff       <= pad_in;
         s1_valid_ff  <= s1_valid_in;
         wp_valid_ff  <= wp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         row_base_ff  <= row_base_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.part_index  = out_part_ff;
   assign rsp_chan.dest_offset = out_offset_ff;
   assign rsp_chan.out_byte    = out_byte_ff;
   assign rsp_chan.image_done  = out_done_ff;

endmodule

/* tb/tb_top.sv */
// testbench for aligned_channel_split: streams padded hwc source bytes and checks each routed byte
// against an in-bench model of the channel split; depends on acs_pkg and the acs channel interfaces

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import acs_pkg::*;

   localparam int CLOCK_HALF       = 10;
   localparam int RESET_CYCLES     = 8;
   localparam int IDLE_PERCENT     = 34;
   localparam int ITEM_TARGET      = 1050;
   // receiver and sender never idle while the sent byte count is in this window
   localparam int STEADY_START     = 450;
   localparam int STEADY_END       = 650;
   // padding bytes may still be in flight after the last transfer
   localparam int DRAIN_CYCLES     = 8;
   // covers the geometry recompute after csr writes plus long random stalls
   localparam int STALL_LIMIT      = 2000;
   localparam int REPORT_LIMIT     = 10;
   localparam int CSR_SLOTS        = 8;
   localparam logic [2:0] REG_UNUSED = 3'd7;

   typedef struct packed {
      logic [1:0]        part_index;
      logic [31:0]       dest_offset;
      logic signed [7:0] out_byte;
      logic              image_done;
   } route_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [11:0] csr_wdata;

   acs_req_if req_bus ();
   acs_rsp_if rsp_bus ();

   aligned_channel_split dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus)
   );

   // geometry as the block sees it after clamping
   int unsigned cfg_parts  = 1;
   int unsigned cfg_height = 1;
   int unsigned cfg_width  = 1;
   int unsigned cfg_chan [4] = '{1, 1, 1, 1};

   // walk position through the source buffer
   int unsigned row_idx  = 0;
   int unsigned col_idx  = 0;
   int unsigned part_sel = 0;
   int unsigned chan_idx = 0;
   int unsigned pad_left = 0;
   logic [31:0] row_base [4] = '{0, 0, 0, 0};
   logic [31:0] wr_ptr   [4] = '{0, 0, 0, 0};

   route_type   pending_routes [$];
   int unsigned error_count  = 0;
   int unsigned sent_items   = 0;
   int unsigned stall_cycles = 0;
   bit          steady       = 1'b0;

   initial begin
      clock = 1'b0;
      forever #(CLOCK_HALF) clock = ~clock;
   end

   // zero acts as one, anything above the limit acts as the limit
   function automatic int unsigned limit_reg(input int unsigned raw, input int unsigned hi);
      if (raw == 0) return 1;
      return (raw > hi) ? hi : raw;
   endfunction

   function automatic int unsigned round_to_align(input int unsigned n);
      return ((n + ACS_ALIGN - 1) / ACS_ALIGN) * ACS_ALIGN;
   endfunction

   // bytes in one pixel summed over the active parts
   function automatic int unsigned pixel_span();
      int unsigned span;
      span = 0;
      for (int i = 0; i < 4 && i < cfg_parts; i++) span += cfg_chan[i];
      return span;
   endfunction

   function automatic void update_geometry(input logic [2:0] idx, input logic [11:0] val);
      case (idx)
         REG_PART_COUNT: cfg_parts  = limit_reg(32'(val[2:0]), ACS_MAX_PARTS);
         REG_HEIGHT:     cfg_height = limit_reg(32'(val), 32'(MAX_DIM));
         REG_WIDTH:      cfg_width  = limit_reg(32'(val), 32'(MAX_DIM));
         REG_PART0_CH, REG_PART1_CH, REG_PART2_CH, REG_PART3_CH: begin
            cfg_chan[idx - REG_PART0_CH] = limit_reg(32'(val[10:0]), 32'(MAX_CH));
         end
         default: ;
      endcase
   endfunction

   // advances the walk by one source byte; returns 1 when the byte is routed to a part
   function automatic bit route_byte(input logic signed [7:0] b, output route_type r);
      int unsigned p;
      int unsigned row_bytes;
      r = '0;
      if (pad_left > 0) begin
         pad_left--;
         return 1'b0;
      end
      p = part_sel & 3;
      r.part_index  = 2'(p);
      r.dest_offset = wr_ptr[p];
      r.out_byte    = b;
      wr_ptr[p] = wr_ptr[p] + 32'd1;
      // every end test is reached-or-passed, so a shrunk limit ends the span at once
      if (chan_idx + 1 >= cfg_chan[p]) begin
         chan_idx = 0;
         if (part_sel + 1 >= cfg_parts) begin
            part_sel = 0;
            if (col_idx + 1 >= cfg_width) begin
               col_idx   = 0;
               row_bytes = pixel_span() * cfg_width;
               pad_left  = round_to_align(row_bytes) - row_bytes;
               if (row_idx + 1 >= cfg_height) begin
                  row_idx = 0;
                  r.image_done = 1'b1;
                  for (int i = 0; i < 4; i++) row_base[i] = '0;
               end else begin
                  row_idx++;
                  for (int i = 0; i < 4; i++) begin
                     row_base[i] = row_base[i] + round_to_align(cfg_chan[i] * cfg_width);
                  end
               end
               for (int i = 0; i < 4; i++) wr_ptr[i] = row_base[i];
            end else begin
               col_idx++;
            end
         end else begin
            part_sel = (part_sel + 1) & 3;
         end
      end else begin
         chan_idx++;
      end
      return 1'b1;
   endfunction

   function automatic void log_failure(input string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT) $display("%s", msg);
   endfunction

   // one source byte transfer, with random idle cycles ahead of it
   task automatic send_byte(input logic signed [7:0] b);
      route_type r;
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.pixel_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      sent_items++;
      if (route_byte(b, r)) begin
         pending_routes.push_back(r);
      end
      steady = (sent_items >= STEADY_START && sent_items < STEADY_END);
   endtask

   // stop sending and let every routed byte and trailing padding clear the block
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (pending_routes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // writes every csr slot, the unused one included, while the block is idle
   task automatic program_regs(input logic [11:0] v [CSR_SLOTS]);
      wait_drained();
      for (int i = 0; i < CSR_SLOTS; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= v[i];
         @(posedge clock);
         update_geometry(3'(i), v[i]);
      end
      csr_wr_en <= 1'b0;
   endtask

   // reset geometry: one real byte per image, fifteen padding bytes after it
   task automatic test_default_geometry();
      send_byte(8'sh7F);
      repeat (15) send_byte(8'($urandom));
      send_byte(8'sh80);
   endtask

   // zero and over-limit register values, largest legal sizes, data extremes
   task automatic test_register_limits();
      logic [11:0] v [CSR_SLOTS];
      v[REG_PART_COUNT] = 12'hFFF;   // low three bits give 7, acts as four parts
      v[REG_HEIGHT]     = 12'hFFF;
      v[REG_WIDTH]      = 12'd2048;
      v[REG_PART0_CH]   = 12'h000;
      v[REG_PART1_CH]   = 12'h7FF;
      v[REG_PART2_CH]   = 12'd1024;
      v[REG_PART3_CH]   = 12'h800;   // bit 11 is dropped, leaving zero
      v[REG_UNUSED]     = 12'hFFF;
      program_regs(v);
      send_byte(8'sh80);
      send_byte(8'sh7F);
      send_byte(8'sh00);
      send_byte(8'shFF);
      send_byte(8'sh01);
      send_byte(8'sh55);
   endtask

   // mostly whole small images; some wide raw geometries and images cut short
   task automatic test_random_images();
      logic [11:0] v [CSR_SLOTS];
      int unsigned image_bytes;
      int unsigned count;
      while (sent_items < ITEM_TARGET) begin
         if ($urandom_range(0, 9) == 0) begin
            // raw values over the whole field, the walk keeps its position
            foreach (v[i]) begin
               case ($urandom_range(0, 2))
                  0:       v[i] = 12'h000;
                  1:       v[i] = 12'hFFF;
                  default: v[i] = 12'($urandom);
               endcase
            end
            program_regs(v);
            repeat ($urandom_range(5, 40)) send_byte(8'($urandom));
         end else begin
            v[REG_PART_COUNT] = 12'($urandom_range(0, 4));
            v[REG_HEIGHT]     = 12'($urandom_range(1, 3));
            v[REG_WIDTH]      = 12'($urandom_range(1, 5));
            v[REG_PART0_CH]   = 12'($urandom_range(1, 4));
            v[REG_PART1_CH]   = 12'($urandom_range(1, 4));
            v[REG_PART2_CH]   = 12'($urandom_range(1, 4));
            v[REG_PART3_CH]   = 12'($urandom_range(1, 4));
            v[REG_UNUSED]     = 12'($urandom);
            program_regs(v);
            // finish whatever image an earlier phase left open under the new geometry
            while ((row_idx != 0 || col_idx != 0 || part_sel != 0 || chan_idx != 0 ||
                    pad_left != 0) && sent_items < ITEM_TARGET) begin
               send_byte(8'($urandom));
            end
            image_bytes = cfg_height * round_to_align(pixel_span() * cfg_width);
            count = image_bytes * $urandom_range(1, 2);
            if ($urandom_range(0, 4) == 0) count = $urandom_range(1, image_bytes);
            for (int unsigned n = 0; n < count && sent_items < ITEM_TARGET; n++) begin
               send_byte(8'($urandom));
            end
         end
      end
   endtask

   // result side: random backpressure, each transfer checked against the oldest route
   always @(posedge clock) begin : check_routes
      route_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_routes.size() == 0) begin
               log_failure($sformatf("unexpected transfer: part %0d offset %0d byte %0d done %0d",
                  rsp_bus.part_index, rsp_bus.dest_offset, rsp_bus.out_byte,
                  rsp_bus.image_done));
            end else begin
               want = pending_routes.pop_front();
               if (rsp_bus.part_index !== want.part_index ||
                   rsp_bus.dest_offset !== want.dest_offset ||
                   rsp_bus.out_byte !== want.out_byte ||
                   rsp_bus.image_done !== want.image_done) begin
                  log_failure($sformatf({"route mismatch: expected part %0d offset %0d byte %0d",
                     " done %0d, got part %0d offset %0d byte %0d done %0d"},
                     want.part_index, want.dest_offset, want.out_byte, want.image_done,
                     rsp_bus.part_index, rsp_bus.dest_offset, rsp_bus.out_byte,
                     rsp_bus.image_done));
               end
            end
         end
         rsp_bus.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // watchdog: too many cycles with no transfer on either side ends the run
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      // block inputs driven from here known from time zero
      reset              <= 1'b1;
      csr_wr_en          <= 1'b0;
      csr_index          <= '0;
      csr_wdata          <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.pixel_byte <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_default_geometry();
      test_register_limits();
      test_random_images();
      wait_drained();

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

/* sim.f */
design/acs_pkg.sv
design/acs_channels.sv
design/acs_geom.sv
design/aligned_channel_split.sv
tb/tb_top.sv
